>>> hw/rtl/laplacian_edge_filter_rgb_assert.svh
// Assertion helpers for the checker file.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef LAPLACIAN_EDGE_FILTER_RGB_ASSERT_SVH
`define LAPLACIAN_EDGE_FILTER_RGB_ASSERT_SVH

// Same-cycle implication
`define LEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lef_pkg.sv
package lef_pkg;

  // Fixed field widths
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int DIM_W    = 11;
  localparam int COORD_W  = 10;
  localparam int TAPS     = 9;
  localparam int CENTER   = 4;

  localparam int CHAN_MAX     = 255;
  localparam int MAX_LINE_DEF = 1024;
  localparam int ROW_CAP      = 1024;
  localparam int MIN_DIM      = 3;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Packed pixel, red in the low byte
  typedef logic [PIX_W-1:0] pix_t;

  // Per-request emission info carried down the pipe
  typedef struct packed {
    logic               emit_a;   // window result for (col-1, row-1)
    logic               emit_b;   // right border of the row above
    logic               emit_c;   // bottom row pixel itself
    logic               inner;    // window result is interior
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } meta_t;

endpackage

>>> hw/rtl/lef_lane.sv
// One color channel of the 3x3 Laplacian: 8*center minus the eight neighbors,
// clamped to 0..CHAN_MAX.
module lef_lane
  import lef_pkg::*;
(
  input  logic [CHAN_W-1:0] taps [TAPS],
  output logic [CHAN_W-1:0] result
);

  logic [CHAN_W+2:0]        nbr_sum;
  logic signed [CHAN_W+3:0] diff;

  // Neighbor sum, at most 8*255
  always_comb begin
    nbr_sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (i != CENTER) begin
        nbr_sum = nbr_sum + (CHAN_W+3)'(taps[i]);
      end
    end
  end

  assign diff = $signed({1'b0, taps[CENTER], 3'b000}) - $signed({1'b0, nbr_sum});

  // Clamp to pixel range
  always_comb begin
    priority if (diff[CHAN_W+3]) begin
      result = '0;
    end else if (diff > $signed((CHAN_W+4)'(CHAN_MAX))) begin
      result = CHAN_W'(CHAN_MAX);
    end else begin
      result = diff[CHAN_W-1:0];
    end
  end

endmodule

>>> hw/rtl/lef_window.sv
// Line store and 3x3 window. Stage 1 reads the two stored rows at the
// request's column; stage 2 shifts the window and writes the column back.
module lef_window
  import lef_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF,
  parameter int AW       = 10
)(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          accept,
  input  pix_t          in_pix,
  input  meta_t         in_meta,
  input  logic [AW-1:0] rd_addr,
  output pix_t          win [TAPS],
  output logic          v2,
  output meta_t         meta2
);

  // {row r-2, row r-1} per column
  logic [2*PIX_W-1:0] mem [MAX_LINE];
  logic [2*PIX_W-1:0] rd_q_r;

  logic          v1_r;
  pix_t          px1_r;
  meta_t         meta1_r;
  logic [AW-1:0] addr1_r;

  pix_t  win_r [TAPS];
  logic  v2_r;
  meta_t meta2_r;

  pix_t top_px;
  pix_t mid_px;

  assign top_px = rd_q_r[2*PIX_W-1:PIX_W];
  assign mid_px = rd_q_r[PIX_W-1:0];

  // Line store: read at accept, write back in stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      rd_q_r <= mem[rd_addr];
    end
    if (en && v1_r) begin
      mem[addr1_r] <= {mid_px, px1_r};
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      px1_r   <= in_pix;
      meta1_r <= in_meta;
      addr1_r <= rd_addr;
      meta2_r <= meta1_r;
    end
  end

  // Window shift: new column enters on the right
  always_ff @(posedge clk) begin
    if (en && v1_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= top_px;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mid_px;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= px1_r;
    end
  end

  assign win   = win_r;
  assign v2    = v2_r;
  assign meta2 = meta2_r;

endmodule

>>> hw/rtl/lef_merge.sv
// Collects the three lane results with the request's coordinates and sends
// up to three results, one per cycle while out_stall is low, in the order
// window, right border, bottom row.
module lef_merge
  import lef_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               v2,
  input  meta_t              meta2,
  input  pix_t               lap,
  input  logic [COORD_W-1:0] wm1,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [CHAN_W-1:0]  out_red,
  output logic [CHAN_W-1:0]  out_green,
  output logic [CHAN_W-1:0]  out_blue,
  output logic [COORD_W-1:0] out_col,
  output logic [COORD_W-1:0] out_row,
  output logic               out_run_last,
  output logic               take
);

  logic [2:0]         pend_r, pend_nxt;
  pix_t               lap_r;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;

  logic [2:0] low_bit;
  logic       single;
  logic       out_fire;
  pix_t       sel_px;

  assign low_bit   = pend_r & (~pend_r + 3'd1);
  assign single    = (pend_r != 3'b000) && (low_bit == pend_r);
  assign out_valid = (pend_r != 3'b000);
  assign out_fire  = out_valid && !out_stall;
  assign take      = !out_valid || (out_fire && single);

  // Pending result mask
  always_comb begin
    pend_nxt = pend_r;
    priority if (take) begin
      pend_nxt = v2 ? {meta2.emit_c, meta2.emit_b, meta2.emit_a} : 3'b000;
    end else if (out_fire) begin
      pend_nxt = pend_r & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'b000;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Bundle payload
  always_ff @(posedge clk) begin
    if (take) begin
      lap_r <= meta2.inner ? lap : '0;
      col_r <= meta2.col;
      row_r <= meta2.row;
    end
  end

  // Select the current result
  always_comb begin
    priority if (pend_r[0]) begin
      sel_px  = lap_r;
      out_col = col_r - COORD_W'(1);
      out_row = row_r - COORD_W'(1);
    end else if (pend_r[1]) begin
      sel_px  = '0;
      out_col = wm1;
      out_row = row_r - COORD_W'(1);
    end else begin
      sel_px  = '0;
      out_col = col_r;
      out_row = row_r;
    end
  end

  assign out_red      = sel_px[CHAN_W-1:0];
  assign out_green    = sel_px[2*CHAN_W-1:CHAN_W];
  assign out_blue     = sel_px[3*CHAN_W-1:2*CHAN_W];
  assign out_run_last = single;

endmodule

>>> hw/rtl/laplacian_edge_filter_rgb.sv
// 3x3 Laplacian edge filter on a raster RGB stream. One pixel is taken per
// clock while in_stall is low; a request passes the window's stage 1 and
// stage 2 registers and the merge's result register. The result port carries
// one result per clock while out_stall is low, so a request with more than one
// result (the last column of every row but the first, and every pixel of the
// last row but its first) holds the input stalled until its extra results
// have gone out. Two rows are kept in a single MAX_LINE-deep line store of two
// packed pixels per word, read at the input and written back in stage 2; it is
// not cleared after reset, since rows left from reset or a previous frame only
// reach border results, which are always zero. Results carry their own column
// and row, and the last result of each request has out_run_last set. A write to
// either dimension register restarts the frame at the top-left pixel; widths
// are clamped to 3..min(MAX_LINE,1024) and heights to 3..1024.
module laplacian_edge_filter_rgb
  import lef_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [DIM_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAN_W-1:0]  in_red,
  input  logic [CHAN_W-1:0]  in_green,
  input  logic [CHAN_W-1:0]  in_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAN_W-1:0]  out_red,
  output logic [CHAN_W-1:0]  out_green,
  output logic [CHAN_W-1:0]  out_blue,
  output logic [COORD_W-1:0] out_col,
  output logic [COORD_W-1:0] out_row,
  output logic               out_run_last
);

  localparam int COL_CAP = (MAX_LINE < ROW_CAP) ? MAX_LINE : ROW_CAP;
  localparam int AW      = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

  logic [DIM_W-1:0]   frame_width_r, frame_width_nxt;
  logic [DIM_W-1:0]   frame_height_r, frame_height_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [COORD_W-1:0] wm1, hm1;
  logic               en, accept;
  meta_t              in_meta;
  pix_t               win [TAPS];
  logic               v2;
  meta_t              meta2;
  pix_t               lap;

  // Clamp dimensions to the supported range
  always_comb begin
    priority if (frame_width_r < DIM_W'(MIN_DIM)) begin
      w_eff = DIM_W'(MIN_DIM);
    end else if (frame_width_r > DIM_W'(COL_CAP)) begin
      w_eff = DIM_W'(COL_CAP);
    end else begin
      w_eff = frame_width_r;
    end
    priority if (frame_height_r < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (frame_height_r > DIM_W'(ROW_CAP)) begin
      h_eff = DIM_W'(ROW_CAP);
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign wm1 = COORD_W'(w_eff - DIM_W'(1));
  assign hm1 = COORD_W'(h_eff - DIM_W'(1));

  assign in_stall = !en;
  assign accept   = in_valid && en;

  // Config registers and raster counters
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    priority if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == wm1) begin
        col_nxt = '0;
        row_nxt = (row_r == hm1) ? '0 : row_r + COORD_W'(1);
      end else begin
        col_nxt = col_r + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
    end
  end

  // Which results this request will cause
  always_comb begin
    in_meta.emit_a = (row_r != '0) && (col_r != '0);
    in_meta.emit_b = (row_r != '0) && (col_r == wm1);
    in_meta.emit_c = (row_r == hm1);
    in_meta.inner  = (row_r >= COORD_W'(2)) && (col_r >= COORD_W'(2));
    in_meta.col    = col_r;
    in_meta.row    = row_r;
  end

  lef_window #(
    .MAX_LINE (MAX_LINE),
    .AW       (AW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .accept  (accept),
    .in_pix  ({in_blue, in_green, in_red}),
    .in_meta (in_meta),
    .rd_addr (AW'(col_r)),
    .win     (win),
    .v2      (v2),
    .meta2   (meta2)
  );

  // One lane per color channel
  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [CHAN_W-1:0] taps [TAPS];
    for (genvar i = 0; i < TAPS; i++) begin : g_tap
      assign taps[i] = win[i][k*CHAN_W +: CHAN_W];
    end
    lef_lane u_lane (
      .taps   (taps),
      .result (lap[k*CHAN_W +: CHAN_W])
    );
  end

  lef_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .v2           (v2),
    .meta2        (meta2),
    .lap          (lap),
    .wm1          (wm1),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_run_last (out_run_last),
    .take         (en)
  );

endmodule

>>> hw/rtl/lef_checker.sv
`include "laplacian_edge_filter_rgb_assert.svh"

// Port-level checks, bound to the top level.
module lef_checker
  import lef_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CHAN_W-1:0]  out_red,
  input logic [CHAN_W-1:0]  out_green,
  input logic [CHAN_W-1:0]  out_blue,
  input logic [COORD_W-1:0] out_col,
  input logic [COORD_W-1:0] out_row,
  input logic               out_run_last
);

  // Stalled result holds
  `LEF_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_col) && $stable(out_row) && $stable(out_red)
      && $stable(out_run_last),
    "stalled result changed")

  // Results of one request go out back to back
  `LEF_ASSERT_NEXT(a_burst, out_valid && !out_stall && !out_run_last, out_valid,
    "gap inside a request's results")

  // Top row and left column are always zero
  `LEF_ASSERT_NOW(a_border_zero, out_valid && (out_col == '0 || out_row == '0),
    out_red == '0 && out_green == '0 && out_blue == '0, "nonzero border result")

  // Input is never held while no result is waiting
  `LEF_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall, "input stalled with empty output")

endmodule

bind laplacian_edge_filter_rgb lef_checker u_lef_checker (.*);
